[hw/rtl/wral_pkg.sv]
// wral_pkg: shared types and constants for the waterfall row auto-level block
// holds the controller state type, register map, field widths and reset values
// no dependencies
package wral_pkg;

    // field widths
    localparam int BIN_W    = 16;
    localparam int OFFSET_W = 15;
    localparam int WEIGHT_W = 16;
    localparam int LEVEL_W  = 8;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    // input item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_FLOOR_OFFSET   = 2'd0;
    localparam logic [1:0] REG_CEILING_OFFSET = 2'd1;
    localparam logic [1:0] REG_SMOOTH_WEIGHT  = 2'd2;

    // register reset values
    localparam logic [OFFSET_W-1:0] FLOOR_OFFSET_RST   = 15'd768;
    localparam logic [OFFSET_W-1:0] CEILING_OFFSET_RST = 15'd10240;
    localparam logic [WEIGHT_W-1:0] SMOOTH_WEIGHT_RST  = 16'd6554;

    // smoothed floor and ceiling reset values, -20 dB and +20 dB in Q7.8
    localparam logic signed [BIN_W-1:0] FLOOR_RST   = -16'sd5120;
    localparam logic signed [BIN_W-1:0] CEILING_RST = 16'sd5120;

    // span lower limit, 1 dB in Q7.8
    localparam logic [BIN_W-1:0] MIN_SPAN = 16'd256;

    // level saturation value
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // smoothing product width: 20-bit difference times 16-bit weight plus old value
    localparam int DIFF_W = 20;
    localparam int PROD_W = 37;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN_INIT,
        ST_MEAN_DIV,
        ST_SMOOTH_SETUP,
        ST_SMOOTH_RUN,
        ST_SMOOTH_DONE,
        ST_READ_WAIT,
        ST_LEVEL_DIV
    } state_t;

endpackage

[hw/rtl/wral_ram.sv]
// wral_ram: generic single-port-write, single-port-read ram with registered read
// width and depth are parameters
// no dependencies
module wral_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/waterfall_row_auto_level.sv]
// waterfall_row_auto_level: top level of the waterfall row auto-level block
// depends on wral_pkg and on wral_ram for the row store
//
// usage
// - command channel: an item (kind, bin_db, row_end) is taken when start is high and
//   busy is low. kind load stores one bin of the row and adds it to the row sum;
//   kind drain asks for the colour level of the next stored bin.
// - a load without row_end leaves busy low, so loads can stream.
// - a load with row_end then closes the row: a set-up step, a bit-serial mean
//   divider over the 16 + clog2(MAX_BINS)-bit row sum, and two bit-serial
//   smoothing multiplies (floor, then ceiling).
// - a drain of a stored bin gives one result: done is high for exactly one
//   cycle with level and last_level. done is registered after the ram read state
//   when the level is clipped at 0 or 255, else after the ram read state and an
//   8-step restoring divider. busy drops in the cycle done is shown.
// - a drain before the row is closed or past its end gives nothing.
//   results cannot be held off by the receiver.
// - the user is to write registers over apb only while the block is idle; the block
//   does not enforce it. pready is always high. reset clears the row, sets floor
//   -20 dB, ceiling +20 dB and register defaults. bins are undefined until loaded.
module waterfall_row_auto_level
    import wral_pkg::*;
#(
    parameter int MAX_BINS = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     kind,
    input  logic signed [BIN_W-1:0]  bin_db,
    input  logic                     row_end,
    output logic                     done,
    output logic [LEVEL_W-1:0]       level,
    output logic                     last_level,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int SUM_W = BIN_W + IDX_W;
    localparam int MC_W  = $clog2(SUM_W);
    localparam int WC_W  = $clog2(WEIGHT_W);
    localparam int LC_W  = $clog2(LEVEL_W);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BINS);

    state_t state_reg, state_next;

    // configuration
    logic [OFFSET_W-1:0] floor_offset_reg;
    logic [OFFSET_W-1:0] ceiling_offset_reg;
    logic [WEIGHT_W-1:0] smoothing_weight_reg;

    // row state
    logic signed [SUM_W-1:0] row_sum_reg, row_sum_next;
    logic [CNT_W-1:0]        bin_count_reg, bin_count_next;
    logic [CNT_W-1:0]        read_index_reg;
    logic                    row_ready_reg;
    logic signed [BIN_W-1:0] smooth_floor_reg;
    logic signed [BIN_W-1:0] smooth_ceiling_reg;

    // mean divider
    logic [SUM_W-1:0] dvd_reg;
    logic [CNT_W:0]   rem_reg;
    logic [MC_W-1:0]  mcnt_reg;
    logic             neg_reg;

    // smoothing multiplier
    logic                     pass_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] mcand_reg;
    logic [WEIGHT_W-1:0]      wsh_reg;
    logic [WC_W-1:0]          scnt_reg;

    // level divider
    logic [23:0]        lrem_reg;
    logic [23:0]        dsr_reg;
    logic [LEVEL_W-1:0] quot_reg;
    logic [LC_W-1:0]    lcnt_reg;
    logic               last_reg;

    // result
    logic               done_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               last_level_reg;

    // ram port
    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    logic [BIN_W-1:0] ram_rdata;

    // handshake and load decode
    logic             accept;
    logic [CNT_W-1:0] eff_count;
    logic             store_ok;
    logic             drain_ok;
    logic             cfg_write;

    assign accept    = start && !busy;
    assign eff_count = row_ready_reg ? '0 : bin_count_reg;
    assign store_ok  = eff_count < MAX_CNT;
    assign drain_ok  = row_ready_reg && (read_index_reg < bin_count_reg);
    assign cfg_write = psel && penable && pwrite && pready;

    // sum and count after a load
    always_comb
    begin
        row_sum_next   = row_ready_reg ? '0 : row_sum_reg;
        bin_count_next = eff_count;
        if (store_ok)
        begin
            row_sum_next   = row_sum_next + SUM_W'(bin_db);
            bin_count_next = eff_count + 1'b1;
        end
    end

    // mean divider step
    logic [SUM_W-1:0] sum_mag;
    logic [CNT_W:0]   rem_shift;
    logic             mdiv_ge;

    assign sum_mag   = row_sum_reg[SUM_W-1] ? SUM_W'(~row_sum_reg + 1'b1) : row_sum_reg;
    assign rem_shift = {rem_reg[CNT_W-1:0], dvd_reg[SUM_W-1]};
    assign mdiv_ge   = rem_shift >= {1'b0, bin_count_reg};

    // smoothing target and difference for the current pass
    logic signed [17:0]       q_mag;
    logic signed [17:0]       mean;
    logic signed [DIFF_W-1:0] mean_x;
    logic signed [DIFF_W-1:0] offset_x;
    logic signed [DIFF_W-1:0] target;
    logic signed [BIN_W-1:0]  sel_old;
    logic signed [DIFF_W-1:0] diff_t;
    logic signed [PROD_W-1:0] p_full;
    logic signed [PROD_W-17:0] p_q;
    logic signed [BIN_W-1:0]  smooth_new;

    assign q_mag    = signed'({1'b0, dvd_reg[16:0]});
    assign mean     = neg_reg ? -q_mag : q_mag;
    assign mean_x   = DIFF_W'(mean);
    assign offset_x = signed'(DIFF_W'(pass_reg ? ceiling_offset_reg : floor_offset_reg));
    assign target   = pass_reg ? (mean_x + offset_x) : (mean_x - offset_x);
    assign sel_old  = pass_reg ? smooth_ceiling_reg : smooth_floor_reg;
    assign diff_t   = target - DIFF_W'(sel_old);

    // floor of p / 65536, then saturate to 16 bits
    assign p_full = (PROD_W'(sel_old) <<< WEIGHT_W) + acc_reg;
    assign p_q    = p_full[PROD_W-1:WEIGHT_W];

    always_comb
    begin
        if (p_q > (PROD_W-16)'(32767))
        begin
            smooth_new = 16'sh7fff;
        end
        else if (p_q < -(PROD_W-16)'(32768))
        begin
            smooth_new = -16'sh8000;
        end
        else
        begin
            smooth_new = p_q[BIN_W-1:0];
        end
    end

    // level numerator and span
    logic signed [BIN_W:0] lvl_diff;
    logic [23:0]           lvl_num;
    logic signed [BIN_W:0] span_raw;
    logic [BIN_W-1:0]      span;
    logic                  lvl_sat;
    logic                  ldiv_ge;

    assign lvl_diff = (BIN_W+1)'(signed'(ram_rdata)) - (BIN_W+1)'(smooth_floor_reg);
    assign lvl_num  = {lvl_diff[BIN_W-1:0], 8'd0} - 24'(lvl_diff[BIN_W-1:0]);
    assign span_raw = (BIN_W+1)'(smooth_ceiling_reg) - (BIN_W+1)'(smooth_floor_reg);
    assign span     = (span_raw < signed'({1'b0, MIN_SPAN})) ? MIN_SPAN : span_raw[BIN_W-1:0];
    assign lvl_sat  = lvl_num >= {span, 8'd0};
    assign ldiv_ge  = lrem_reg >= dsr_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        state_next = row_end ? ST_MEAN_INIT : ST_IDLE;
                    end
                    else
                    begin
                        state_next = drain_ok ? ST_READ_WAIT : ST_IDLE;
                    end
                end
            end
            ST_MEAN_INIT:
            begin
                state_next = ST_MEAN_DIV;
            end
            ST_MEAN_DIV:
            begin
                if (mcnt_reg == '0)
                begin
                    state_next = ST_SMOOTH_SETUP;
                end
            end
            ST_SMOOTH_SETUP:
            begin
                state_next = ST_SMOOTH_RUN;
            end
            ST_SMOOTH_RUN:
            begin
                if (scnt_reg == '0)
                begin
                    state_next = ST_SMOOTH_DONE;
                end
            end
            ST_SMOOTH_DONE:
            begin
                state_next = pass_reg ? ST_IDLE : ST_SMOOTH_SETUP;
            end
            ST_READ_WAIT:
            begin
                state_next = (lvl_diff[BIN_W] || lvl_sat) ? ST_IDLE : ST_LEVEL_DIV;
            end
            ST_LEVEL_DIV:
            begin
                if (lcnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = eff_count[IDX_W-1:0];
        ram_raddr = read_index_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                ram_we = accept && (kind == KIND_LOAD) && store_ok;
                ram_re = accept && (kind == KIND_DRAIN) && drain_ok;
            end
            default:
            begin
                ram_we = 1'b0;
                ram_re = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // row control state and smoothed limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_sum_reg        <= '0;
            bin_count_reg      <= '0;
            read_index_reg     <= '0;
            row_ready_reg      <= 1'b0;
            smooth_floor_reg   <= FLOOR_RST;
            smooth_ceiling_reg <= CEILING_RST;
            pass_reg           <= 1'b0;
            done_reg           <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (kind == KIND_LOAD))
                    begin
                        row_sum_reg   <= row_sum_next;
                        bin_count_reg <= bin_count_next;
                        row_ready_reg <= 1'b0;
                        if (row_ready_reg)
                        begin
                            read_index_reg <= '0;
                        end
                    end
                    else if (accept && drain_ok)
                    begin
                        read_index_reg <= read_index_reg + 1'b1;
                    end
                end
                ST_SMOOTH_DONE:
                begin
                    if (pass_reg)
                    begin
                        smooth_ceiling_reg <= smooth_new;
                        pass_reg           <= 1'b0;
                        row_ready_reg      <= 1'b1;
                        read_index_reg     <= '0;
                    end
                    else
                    begin
                        smooth_floor_reg <= smooth_new;
                        pass_reg         <= 1'b1;
                    end
                end
                ST_READ_WAIT:
                begin
                    if (lvl_diff[BIN_W] || lvl_sat)
                    begin
                        done_reg <= 1'b1;
                    end
                end
                ST_LEVEL_DIV:
                begin
                    if (lcnt_reg == '0)
                    begin
                        done_reg <= 1'b1;
                    end
                end
                default:
                begin
                    done_reg <= 1'b0;
                end
            endcase
        end
    end

    // serial datapath: mean divider, smoothing multiplier, level divider
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                last_reg <= (read_index_reg + 1'b1) == bin_count_reg;
            end
            ST_MEAN_INIT:
            begin
                dvd_reg  <= sum_mag;
                neg_reg  <= row_sum_reg[SUM_W-1];
                rem_reg  <= '0;
                mcnt_reg <= MC_W'(SUM_W - 1);
            end
            ST_MEAN_DIV:
            begin
                rem_reg  <= mdiv_ge ? (rem_shift - {1'b0, bin_count_reg}) : rem_shift;
                dvd_reg  <= {dvd_reg[SUM_W-2:0], mdiv_ge};
                mcnt_reg <= mcnt_reg - 1'b1;
            end
            ST_SMOOTH_SETUP:
            begin
                acc_reg   <= '0;
                mcand_reg <= PROD_W'(diff_t);
                wsh_reg   <= smoothing_weight_reg;
                scnt_reg  <= WC_W'(WEIGHT_W - 1);
            end
            ST_SMOOTH_RUN:
            begin
                if (wsh_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg <= mcand_reg <<< 1;
                wsh_reg   <= wsh_reg >> 1;
                scnt_reg  <= scnt_reg - 1'b1;
            end
            ST_READ_WAIT:
            begin
                last_level_reg <= last_reg;
                if (lvl_diff[BIN_W])
                begin
                    level_reg <= '0;
                end
                else if (lvl_sat)
                begin
                    level_reg <= LEVEL_MAX;
                end
                lrem_reg <= lvl_num;
                dsr_reg  <= {1'b0, span, 7'd0};
                quot_reg <= '0;
                lcnt_reg <= LC_W'(LEVEL_W - 1);
            end
            ST_LEVEL_DIV:
            begin
                if (ldiv_ge)
                begin
                    lrem_reg <= lrem_reg - dsr_reg;
                end
                quot_reg <= {quot_reg[LEVEL_W-2:0], ldiv_ge};
                dsr_reg  <= dsr_reg >> 1;
                lcnt_reg <= lcnt_reg - 1'b1;
                if (lcnt_reg == '0)
                begin
                    level_reg <= {quot_reg[LEVEL_W-2:0], ldiv_ge};
                end
            end
            default:
            begin
                lcnt_reg <= lcnt_reg;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_offset_reg     <= FLOOR_OFFSET_RST;
            ceiling_offset_reg   <= CEILING_OFFSET_RST;
            smoothing_weight_reg <= SMOOTH_WEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_FLOOR_OFFSET:   floor_offset_reg     <= pwdata[OFFSET_W-1:0];
                REG_CEILING_OFFSET: ceiling_offset_reg   <= pwdata[OFFSET_W-1:0];
                REG_SMOOTH_WEIGHT:  smoothing_weight_reg <= pwdata[WEIGHT_W-1:0];
                default:            floor_offset_reg     <= floor_offset_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_FLOOR_OFFSET:   prdata = APB_DW'(floor_offset_reg);
            REG_CEILING_OFFSET: prdata = APB_DW'(ceiling_offset_reg);
            REG_SMOOTH_WEIGHT:  prdata = APB_DW'(smoothing_weight_reg);
            default:            prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign done       = done_reg;
    assign level      = level_reg;
    assign last_level = last_level_reg;

    // row store
    wral_ram #(
        .WIDTH (BIN_W),
        .DEPTH (MAX_BINS)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (bin_db),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a result only ever follows the read or the level divider
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_READ_WAIT || $past(state_reg) == ST_LEVEL_DIV))
        else $error("result strobe without a level computation");

    // an accepted item never gives a result in the next cycle
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !done)
        else $error("result strobe directly after an accepted item");

    // the mean divider never runs on an empty row
    a_mean_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MEAN_DIV) |-> (bin_count_reg != '0))
        else $error("mean division by a zero bin count");

    // the drain pointer never passes the row length
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_ready_reg |-> (read_index_reg <= bin_count_reg))
        else $error("read index beyond the stored row");

endmodule

[bench/waterfall_row_auto_level_tb.sv]
// testbench for waterfall_row_auto_level: command items in, level results checked in order
// uses wral_pkg for widths, item kinds, register indexes and reset values
// self-checking against an in-bench auto-level predictor, apb writes between phases
module waterfall_row_auto_level_tb
    import wral_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_DEPTH     = 1024;
    // idle wait after the block goes quiet, longer than a row close or a level divide
    localparam int CLOSE_CYCLES  = 80;
    localparam int PHASE_ITEMS   = 115;

    typedef struct packed {
        logic              kind;
        logic [BIN_W-1:0]  bin;
        logic              last;
        logic              wait_drained;
    } bin_cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               last;
    } level_exp_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, known from time zero
    logic                    start   = 1'b0;
    logic                    kind    = KIND_LOAD;
    logic signed [BIN_W-1:0] bin_db  = '0;
    logic                    row_end = 1'b0;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [APB_AW-1:0]       paddr   = '0;
    logic [APB_DW-1:0]       pwdata  = '0;

    // block outputs
    logic               busy;
    logic               done;
    logic [LEVEL_W-1:0] level;
    logic               last_level;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // items waiting to be driven and levels waiting to arrive
    bin_cmd_t   pending_items[$];
    level_exp_t expected_levels[$];

    bit          accepted_now = 1'b0;
    int unsigned gap_pct      = 0;
    int          fail_count   = 0;

    // run statistics
    int queued_total  = 0;
    int loads_taken   = 0;
    int drains_taken  = 0;
    int rows_closed   = 0;
    int levels_seen   = 0;
    int reg_writes    = 0;
    int drain_pauses  = 0;

    // predictor state
    logic signed [BIN_W-1:0] row_bins [0:ROW_DEPTH-1];
    longint                  row_total  = 0;
    int                      row_len    = 0;
    int                      drain_pos  = 0;
    bit                      row_closed = 1'b0;
    logic signed [BIN_W-1:0] floor_q78  = FLOOR_RST;
    logic signed [BIN_W-1:0] ceil_q78   = CEILING_RST;

    // predictor copy of the registers
    logic [OFFSET_W-1:0] cfg_floor_off = FLOOR_OFFSET_RST;
    logic [OFFSET_W-1:0] cfg_ceil_off  = CEILING_OFFSET_RST;
    logic [WEIGHT_W-1:0] cfg_weight    = SMOOTH_WEIGHT_RST;

    bin_cmd_t   drive_cmd;
    bin_cmd_t   head_cmd;
    bin_cmd_t   taken_cmd;
    level_exp_t want;

    waterfall_row_auto_level #(
        .MAX_BINS (ROW_DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .bin_db     (bin_db),
        .row_end    (row_end),
        .done       (done),
        .level      (level),
        .last_level (last_level),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // exponential smoothing, floor rounding, saturated to q7.8
    function automatic logic signed [BIN_W-1:0] smooth_toward(
        input logic signed [BIN_W-1:0] old,
        input longint                  target,
        input logic [WEIGHT_W-1:0]     w
    );
        longint blend;
        longint q;
        blend = longint'(old) * (longint'(65536) - longint'(w)) + target * longint'(w);
        q = blend >>> 16;
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return q[BIN_W-1:0];
    endfunction

    // auto-level predictor: one accepted item in, at most one level out
    task automatic auto_level_step(input bin_cmd_t c);
        longint     mean;
        longint     span;
        longint     num;
        longint     lvl;
        level_exp_t e;
        if (c.kind == KIND_LOAD)
        begin
            loads_taken++;
            // a load after a closed row opens a new one
            if (row_closed)
            begin
                row_closed = 1'b0;
                row_total  = 0;
                row_len    = 0;
                drain_pos  = 0;
            end
            // bins past the store depth are dropped
            if (row_len < ROW_DEPTH)
            begin
                row_bins[row_len] = $signed(c.bin);
                row_total += longint'($signed(c.bin));
                row_len++;
            end
            if (c.last)
            begin
                mean      = row_total / longint'(row_len);
                floor_q78 = smooth_toward(floor_q78, mean - longint'(cfg_floor_off),
                                          cfg_weight);
                ceil_q78  = smooth_toward(ceil_q78, mean + longint'(cfg_ceil_off),
                                          cfg_weight);
                row_closed = 1'b1;
                drain_pos  = 0;
                rows_closed++;
            end
        end
        else
        begin
            drains_taken++;
            // nothing before the row closes or past its end
            if (row_closed && drain_pos < row_len)
            begin
                span = longint'(ceil_q78) - longint'(floor_q78);
                if (span < longint'(MIN_SPAN))
                    span = longint'(MIN_SPAN);
                num = (longint'(row_bins[drain_pos]) - longint'(floor_q78)) * 255;
                if (num < 0)
                    lvl = 0;
                else
                    lvl = num / span;
                if (lvl > longint'(LEVEL_MAX))
                    lvl = longint'(LEVEL_MAX);
                e.level = lvl[LEVEL_W-1:0];
                e.last  = (drain_pos + 1 == row_len);
                expected_levels.push_back(e);
                drain_pos++;
            end
        end
    endtask

    // item driver, inputs change on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !accepted_now)
            start <= 1'b1;
        else if (pending_items.size() != 0)
        begin
            head_cmd = pending_items[0];
            if ((head_cmd.wait_drained && expected_levels.size() != 0)
                || $urandom_range(99) < gap_pct)
                start <= 1'b0;
            else
            begin
                drive_cmd = pending_items.pop_front();
                start   <= 1'b1;
                kind    <= drive_cmd.kind;
                bin_db  <= drive_cmd.bin;
                row_end <= drive_cmd.last;
            end
        end
        else
            start <= 1'b0;
    end

    // result monitor and item acceptance, sampled on the rising edge
    always @(posedge clk)
    begin
        accepted_now = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                levels_seen++;
                if (expected_levels.size() == 0)
                begin
                    $error("level result with nothing expected: level %0d last_level %0b",
                           level, last_level);
                    fail_count++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (level !== want.level)
                    begin
                        $error("level: expected %0d, actual %0d", want.level, level);
                        fail_count++;
                    end
                    if (last_level !== want.last)
                    begin
                        $error("last_level: expected %0b, actual %0b", want.last, last_level);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                accepted_now = 1'b1;
                taken_cmd.kind         = kind;
                taken_cmd.bin          = bin_db;
                taken_cmd.last         = row_end;
                taken_cmd.wait_drained = 1'b0;
                auto_level_step(taken_cmd);
            end
        end
    end

    // queue one item; drains carry random, ignored fields
    task automatic queue_cmd(input logic k, input logic [BIN_W-1:0] b, input logic l,
                             input bit wait_drained);
        bin_cmd_t c;
        c.kind         = k;
        c.bin          = (k == KIND_DRAIN) ? 16'($urandom) : b;
        c.last         = (k == KIND_DRAIN) ? 1'($urandom) : l;
        c.wait_drained = wait_drained;
        if (wait_drained)
            drain_pauses++;
        pending_items.push_back(c);
        queued_total++;
    endtask

    function automatic logic [BIN_W-1:0] pick_bin(input int centre, input int spread);
        int v;
        v = centre + int'($urandom_range(2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[BIN_W-1:0];
    endfunction

    // apb write: setup cycle, then access cycle
    task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_FLOOR_OFFSET:   cfg_floor_off = val[OFFSET_W-1:0];
            REG_CEILING_OFFSET: cfg_ceil_off  = val[OFFSET_W-1:0];
            REG_SMOOTH_WEIGHT:  cfg_weight    = val[WEIGHT_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // wait until all items are in, all levels out and the block has gone quiet
    task automatic wait_quiet();
        @(negedge clk);
        while (pending_items.size() != 0 || start || expected_levels.size() != 0)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        repeat (CLOSE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input int fo, input int co, input int w);
        reg_write(REG_FLOOR_OFFSET, APB_DW'(fo));
        reg_write(REG_CEILING_OFFSET, APB_DW'(co));
        reg_write(REG_SMOOTH_WEIGHT, APB_DW'(w));
    endtask

    // mostly whole rows then drains, with some noise and broken rows
    task automatic queue_random_rows(input int target);
        int   first;
        int   n;
        int   n_drain;
        int   style;
        int   centre;
        int   spread;
        bit   sync;
        logic [BIN_W-1:0] b;
        first = queued_total;
        while (queued_total - first < target)
        begin
            if ($urandom_range(99) < 85)
            begin
                n      = ($urandom_range(19) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(1, 12);
                style  = $urandom_range(9);
                sync   = ($urandom_range(29) == 0);
                spread = 1500;
                if (style <= 5)
                    centre = int'($urandom_range(16000)) - 8000;
                else if (style == 8)
                begin
                    centre = 32767 - int'($urandom_range(2000));
                    spread = 500;
                end
                else if (style == 9)
                begin
                    centre = -32768 + int'($urandom_range(2000));
                    spread = 500;
                end
                for (int i = 0; i < n; i++)
                begin
                    // early drain; after the first load of the row it gives nothing
                    if ($urandom_range(9) == 0)
                        queue_cmd(KIND_DRAIN, '0, 1'b0, 1'b0);
                    if (style == 6 || style == 7)
                        b = 16'($urandom);
                    else
                        b = pick_bin(centre, spread);
                    queue_cmd(KIND_LOAD, b, (i == n - 1), sync && (i == 0));
                end
                n_drain = ($urandom_range(99) < 85) ? n + $urandom_range(2) : $urandom_range(n);
                for (int i = 0; i < n_drain; i++)
                    queue_cmd(KIND_DRAIN, '0, 1'b0, 1'b0);
            end
            else
                queue_cmd(1'($urandom), 16'($urandom), 1'($urandom), 1'b0);
        end
    endtask

    // one random phase under one register setting
    task automatic run_phase(input int fo, input int co, input int w, input int unsigned gap);
        wait_quiet();
        write_regs(fo, co, w);
        gap_pct = gap;
        queue_random_rows(PHASE_ITEMS);
    endtask

    // stimulus and end of run
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part: full move to target, wide ceiling
        wait_quiet();
        write_regs(0, 16384, 65535);
        gap_pct = 0;
        queue_cmd(KIND_DRAIN, '0, 1'b0, 1'b0);            // drain before any row
        queue_cmd(KIND_LOAD, 16'h8000, 1'b0, 1'b0);
        queue_cmd(KIND_DRAIN, '0, 1'b0, 1'b0);            // drain with row still open
        queue_cmd(KIND_LOAD, 16'h7FFF, 1'b0, 1'b0);
        queue_cmd(KIND_LOAD, 16'h0000, 1'b1, 1'b0);
        repeat (5) queue_cmd(KIND_DRAIN, '0, 1'b0, 1'b0);  // two past the end
        queue_cmd(KIND_LOAD, 16'h5555, 1'b1, 1'b0);      // single-bin row after a closed one
        queue_cmd(KIND_DRAIN, '0, 1'b0, 1'b0);
        queue_cmd(KIND_LOAD, 16'hAAAA, 1'b0, 1'b1);
        queue_cmd(KIND_LOAD, 16'h0064, 1'b1, 1'b0);
        queue_cmd(KIND_DRAIN, '0, 1'b0, 1'b0);            // row left half drained
        queue_cmd(KIND_LOAD, 16'h0100, 1'b1, 1'b0);
        repeat (2) queue_cmd(KIND_DRAIN, '0, 1'b0, 1'b0);

        // random phases over several settings, extremes among them
        run_phase(FLOOR_OFFSET_RST, CEILING_OFFSET_RST, SMOOTH_WEIGHT_RST, 19);
        run_phase(16384, 0, 0, 19);
        run_phase($urandom_range(32767), $urandom_range(32767), $urandom_range(65535), 49);
        run_phase(0, 0, 65535, 49);
        run_phase($urandom_range(16384), $urandom_range(16384), $urandom_range(65535), 0);
        run_phase(32767, 32767, 32768, 0);
        wait_quiet();

        if (expected_levels.size() != 0)
        begin
            $error("%0d expected levels never arrived", expected_levels.size());
            fail_count++;
        end
        $display("run covered %0d loads and %0d drains over %0d closed rows, %0d register writes",
                 loads_taken, drains_taken, rows_closed, reg_writes);
        $display("%0d levels compared, %0d drain pauses, %0d failures",
                 levels_seen, drain_pauses, fail_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hard stop if the block hangs
    initial
    begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
